// ===== rtl/hpq_pkg.sv =====
`default_nettype none

package hpq_pkg;

  localparam int KEY_W       = 32;
  localparam int COUNT_W     = 6;
  localparam int INDEX_W     = 5;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int DEF_CAPACITY = 32;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 6'd32;

  localparam logic [PADDR_W-3:0] REG_CAPACITY_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_EXTRACT  = 2'd1,
    CMD_DECREASE = 2'd2,
    CMD_DELETE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_FULL   = 3'd1,
    STAT_EMPTY  = 3'd2,
    STAT_BADIDX = 3'd3,
    STAT_NODEC  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_UP,
    ST_DOWN,
    ST_PLACE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [KEY_W-1:0]  key_value;
    logic [INDEX_W-1:0]       entry_index;
  } cmd_word_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  taken_value;
    logic signed [KEY_W-1:0]  min_value;
    logic [COUNT_W-1:0]       entry_count;
    status_t                  status;
  } rsp_word_t;

endpackage

`default_nettype wire

// ===== rtl/min_heap_priority_queue_top.sv =====
`default_nettype none

// Binary min-heap priority queue of signed 32-bit keys held in one
// synchronous RAM (two read ports, one write port). One command word is
// worked at a time, in these steps: accept it and read its operands,
// decode them, walk the sift one heap level per step (the moving key
// stays in a register, so each level is one RAM read and one write),
// place the key, and load the response register. A command that fails
// or places nothing goes from the decode straight to the response load.
// At capacity 32 a sift walks at most five levels. A finished response
// waits in its output register while the next command is accepted; a
// response still held there stalls the next load.
// capacity_limit (APB offset 0, reset 32) caps the count; values above
// CAPACITY act as CAPACITY. Failing commands leave the heap unchanged.
module min_heap_priority_queue_top #(
  parameter int CAPACITY = hpq_pkg::DEF_CAPACITY
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output      logic                          cmd_ready,
  input  wire hpq_pkg::cmd_word_t            cmd_word,
  output      logic                          rsp_valid,
  input  wire logic                          rsp_ready,
  output      hpq_pkg::rsp_word_t            rsp_word,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hpq_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [hpq_pkg::PDATA_W-1:0]   pwdata,
  output      logic [hpq_pkg::PDATA_W-1:0]   prdata,
  output      logic                          pready
);

  logic [hpq_pkg::COUNT_W-1:0]   limit;
  logic [hpq_pkg::PADDR_W-3:0]   reg_index;
  logic                          wr_limit;

  assign pready    = 1'b1;
  assign reg_index = paddr[hpq_pkg::PADDR_W-1:2];
  assign wr_limit  = psel && penable && pwrite && (reg_index == hpq_pkg::REG_CAPACITY_LIMIT);
  assign prdata    = (reg_index == hpq_pkg::REG_CAPACITY_LIMIT) ?
                     hpq_pkg::PDATA_W'(limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= hpq_pkg::LIMIT_RESET;
    end else if (wr_limit) begin
      limit <= pwdata[hpq_pkg::COUNT_W-1:0];
    end
  end

  hpq_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .limit     (limit),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_word  (cmd_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
  );

endmodule

`default_nettype wire

// ===== rtl/hpq_mem.sv =====
`default_nettype none

module hpq_mem #(
  parameter int DEPTH = hpq_pkg::DEF_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                             clk,
  input  wire logic                             re,
  input  wire logic [AW-1:0]                    raddr0,
  input  wire logic [AW-1:0]                    raddr1,
  output      logic signed [hpq_pkg::KEY_W-1:0] rdata0,
  output      logic signed [hpq_pkg::KEY_W-1:0] rdata1,
  input  wire logic                             we,
  input  wire logic [AW-1:0]                    waddr,
  input  wire logic signed [hpq_pkg::KEY_W-1:0] wdata
);

  logic signed [hpq_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hpq_engine.sv =====
`default_nettype none

module hpq_engine #(
  parameter int CAPACITY = hpq_pkg::DEF_CAPACITY
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [hpq_pkg::COUNT_W-1:0]  limit,
  input  wire logic                         cmd_valid,
  output      logic                         cmd_ready,
  input  wire hpq_pkg::cmd_word_t           cmd_word,
  output      logic                         rsp_valid,
  input  wire logic                         rsp_ready,
  output      hpq_pkg::rsp_word_t           rsp_word
);

  localparam int AW = $clog2(CAPACITY);
  localparam int WW = ((AW > hpq_pkg::COUNT_W) ? AW : hpq_pkg::COUNT_W) + 2;

  hpq_pkg::state_t state, state_next;
  hpq_pkg::cmd_word_t in_q, in_q_next;
  hpq_pkg::status_t status_q, status_q_next;

  logic [hpq_pkg::COUNT_W-1:0]     count, count_next;
  logic [AW-1:0]                   pos, pos_next;
  logic signed [hpq_pkg::KEY_W-1:0] moving, moving_next;
  logic signed [hpq_pkg::KEY_W-1:0] root, root_next;
  logic signed [hpq_pkg::KEY_W-1:0] taken, taken_next;
  logic                            fallback, fallback_next;
  logic                            rsp_valid_next;
  hpq_pkg::rsp_word_t              rsp_word_next;

  logic                            mem_re, mem_we;
  logic [AW-1:0]                   mem_ra0, mem_ra1, mem_wa;
  logic signed [hpq_pkg::KEY_W-1:0] mem_wd, rd0, rd1;

  hpq_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk    (clk),
    .re     (mem_re),
    .raddr0 (mem_ra0),
    .raddr1 (mem_ra1),
    .rdata0 (rd0),
    .rdata1 (rd1),
    .we     (mem_we),
    .waddr  (mem_wa),
    .wdata  (mem_wd)
  );

  logic          accept, load;
  logic [WW-1:0] count_w, cap_w, limit_w, eff_w, idx_w, in_idx_w;
  logic [WW-1:0] last_w, cnt_par_w, left_w, right_w, child_w;
  logic [WW-1:0] cl_w, cr_w;
  logic [AW-1:0] idx_a, par_pos, par_idx, par_par;
  logic          full, idx_bad, no_dec, idx_zero, del_last, cnt_zero, cnt_one;
  logic          up_swap, par_zero, left_ok, right_ok, pick_r, down_swap;
  logic signed [hpq_pkg::KEY_W-1:0] child_val;

  assign accept   = cmd_valid && cmd_ready;
  assign load     = (state == hpq_pkg::ST_FINISH) && (!rsp_valid || rsp_ready);
  assign cmd_ready = (state == hpq_pkg::ST_IDLE);

  assign count_w  = WW'(count);
  assign cap_w    = WW'(CAPACITY);
  assign limit_w  = WW'(limit);
  assign eff_w    = (limit_w > cap_w) ? cap_w : limit_w;
  assign last_w   = count_w - WW'(1);
  assign cnt_par_w = last_w >> 1;
  assign in_idx_w = WW'(cmd_word.entry_index);
  assign idx_w    = WW'(in_q.entry_index);
  assign idx_a    = idx_w[AW-1:0];

  assign full     = count_w >= eff_w;
  assign idx_bad  = idx_w >= count_w;
  assign no_dec   = in_q.key_value > rd0;
  assign idx_zero = (idx_w == '0);
  assign del_last = (idx_w == last_w);
  assign cnt_zero = (count == '0);
  assign cnt_one  = (count_w == WW'(1));

  assign par_idx  = (idx_a - AW'(1)) >> 1;
  assign par_pos  = (pos - AW'(1)) >> 1;
  assign par_par  = (par_pos - AW'(1)) >> 1;
  assign par_zero = (par_pos == '0);
  assign up_swap  = moving < rd0;

  assign left_w   = WW'({pos, 1'b1});
  assign right_w  = left_w + WW'(1);
  assign left_ok  = left_w < count_w;
  assign right_ok = right_w < count_w;
  assign pick_r   = right_ok && (rd1 < rd0);
  assign child_w  = pick_r ? right_w : left_w;
  assign child_val = pick_r ? rd1 : rd0;
  assign down_swap = left_ok && (child_val < moving);
  assign cl_w     = {child_w[WW-2:0], 1'b1};
  assign cr_w     = cl_w + WW'(1);

  always_comb begin
    state_next = state;
    case (state)
      hpq_pkg::ST_IDLE: begin
        if (cmd_valid) state_next = hpq_pkg::ST_START;
      end
      hpq_pkg::ST_START: begin
        case (in_q.cmd)
          hpq_pkg::CMD_INSERT: begin
            if (full) state_next = hpq_pkg::ST_FINISH;
            else if (cnt_zero) state_next = hpq_pkg::ST_PLACE;
            else state_next = hpq_pkg::ST_UP;
          end
          hpq_pkg::CMD_EXTRACT: begin
            if (cnt_zero || cnt_one) state_next = hpq_pkg::ST_FINISH;
            else state_next = hpq_pkg::ST_DOWN;
          end
          hpq_pkg::CMD_DECREASE: begin
            if (idx_bad || no_dec) state_next = hpq_pkg::ST_FINISH;
            else if (idx_zero) state_next = hpq_pkg::ST_PLACE;
            else state_next = hpq_pkg::ST_UP;
          end
          hpq_pkg::CMD_DELETE: begin
            if (idx_bad || del_last) state_next = hpq_pkg::ST_FINISH;
            else if (idx_zero) state_next = hpq_pkg::ST_DOWN;
            else state_next = hpq_pkg::ST_UP;
          end
          default: state_next = hpq_pkg::ST_FINISH;
        endcase
      end
      hpq_pkg::ST_UP: begin
        if (up_swap) state_next = par_zero ? hpq_pkg::ST_PLACE : hpq_pkg::ST_UP;
        else state_next = fallback ? hpq_pkg::ST_DOWN : hpq_pkg::ST_PLACE;
      end
      hpq_pkg::ST_DOWN: begin
        state_next = down_swap ? hpq_pkg::ST_DOWN : hpq_pkg::ST_PLACE;
      end
      hpq_pkg::ST_PLACE: state_next = hpq_pkg::ST_FINISH;
      hpq_pkg::ST_FINISH: begin
        if (load) state_next = hpq_pkg::ST_IDLE;
      end
      default: state_next = hpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_q_next     = accept ? cmd_word : in_q;
    status_q_next = status_q;
    count_next    = count;
    pos_next      = pos;
    moving_next   = moving;
    taken_next    = taken;
    fallback_next = fallback;
    mem_re        = 1'b0;
    mem_ra0       = idx_a;
    mem_ra1       = last_w[AW-1:0];
    mem_we        = 1'b0;
    mem_wa        = pos;
    mem_wd        = moving;
    case (state)
      hpq_pkg::ST_IDLE: begin
        mem_re  = accept;
        mem_ra0 = (cmd_word.cmd == hpq_pkg::CMD_INSERT) ? cnt_par_w[AW-1:0]
                                                       : in_idx_w[AW-1:0];
      end
      hpq_pkg::ST_START: begin
        status_q_next = hpq_pkg::STAT_OK;
        taken_next    = '0;
        fallback_next = 1'b0;
        case (in_q.cmd)
          hpq_pkg::CMD_INSERT: begin
            if (full) begin
              status_q_next = hpq_pkg::STAT_FULL;
            end else begin
              count_next  = count + hpq_pkg::COUNT_W'(1);
              moving_next = in_q.key_value;
              pos_next    = count_w[AW-1:0];
            end
          end
          hpq_pkg::CMD_EXTRACT: begin
            if (cnt_zero) begin
              status_q_next = hpq_pkg::STAT_EMPTY;
            end else begin
              taken_next  = root;
              count_next  = count - hpq_pkg::COUNT_W'(1);
              moving_next = rd1;
              pos_next    = '0;
              mem_re      = 1'b1;
              mem_ra0     = AW'(1);
              mem_ra1     = AW'(2);
            end
          end
          hpq_pkg::CMD_DECREASE: begin
            if (idx_bad) begin
              status_q_next = hpq_pkg::STAT_BADIDX;
            end else if (no_dec) begin
              status_q_next = hpq_pkg::STAT_NODEC;
            end else begin
              moving_next = in_q.key_value;
              pos_next    = idx_a;
              mem_re      = 1'b1;
              mem_ra0     = par_idx;
            end
          end
          hpq_pkg::CMD_DELETE: begin
            if (idx_bad) begin
              status_q_next = hpq_pkg::STAT_BADIDX;
            end else begin
              taken_next    = rd0;
              count_next    = count - hpq_pkg::COUNT_W'(1);
              moving_next   = rd1;
              pos_next      = idx_a;
              fallback_next = 1'b1;
              mem_re        = 1'b1;
              if (idx_zero) begin
                mem_ra0 = AW'(1);
                mem_ra1 = AW'(2);
              end else begin
                mem_ra0 = par_idx;
              end
            end
          end
          default: status_q_next = hpq_pkg::STAT_OK;
        endcase
      end
      hpq_pkg::ST_UP: begin
        fallback_next = 1'b0;
        if (up_swap) begin
          mem_we   = 1'b1;
          mem_wd   = rd0;
          pos_next = par_pos;
          mem_re   = !par_zero;
          mem_ra0  = par_par;
        end else if (fallback) begin
          mem_re  = 1'b1;
          mem_ra0 = left_w[AW-1:0];
          mem_ra1 = right_w[AW-1:0];
        end
      end
      hpq_pkg::ST_DOWN: begin
        if (down_swap) begin
          mem_we   = 1'b1;
          mem_wd   = child_val;
          pos_next = child_w[AW-1:0];
          mem_re   = 1'b1;
          mem_ra0  = cl_w[AW-1:0];
          mem_ra1  = cr_w[AW-1:0];
        end
      end
      hpq_pkg::ST_PLACE: begin
        mem_we = 1'b1;
      end
      default: mem_re = 1'b0;
    endcase
  end

  assign root_next = (mem_we && mem_wa == '0) ? mem_wd : root;

  always_comb begin
    rsp_word_next = rsp_word;
    rsp_valid_next = rsp_valid && !rsp_ready;
    if (load) begin
      rsp_valid_next            = 1'b1;
      rsp_word_next.taken_value = taken;
      rsp_word_next.min_value   = cnt_zero ? '0 : root;
      rsp_word_next.entry_count = count;
      rsp_word_next.status      = status_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hpq_pkg::ST_IDLE;
      count     <= '0;
      fallback  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      fallback  <= fallback_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    in_q     <= in_q_next;
    status_q <= status_q_next;
    pos      <= pos_next;
    moving   <= moving_next;
    root     <= root_next;
    taken    <= taken_next;
    rsp_word <= rsp_word_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    WW'(count) <= cap_w)
    else $error("heap count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == hpq_pkg::ST_IDLE || state == hpq_pkg::ST_FINISH) |-> !mem_we)
    else $error("memory write outside a command");

  a_up_not_root: assert property (@(posedge clk) disable iff (rst)
    (state == hpq_pkg::ST_UP) |-> (pos != '0))
    else $error("sift up from the root");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> ($past(state) == hpq_pkg::ST_START || $past(rst)))
    else $error("count changed outside command start");

  a_empty_min: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_word.entry_count == '0) |-> (rsp_word.min_value == '0))
    else $error("nonzero minimum on empty heap");

endmodule

`default_nettype wire
